### src/lsd_pkg.sv
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared widths, register indexes and pipeline payload types for the
// linear spring-damper force core.
// ----------------------------------------------------------------------------
package lsd_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned UNIT_BITS     = 30;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIFF_W  = 33;
  localparam int unsigned MAG_W   = 33;
  localparam int unsigned SQ_W    = 65;
  localparam int unsigned SUM_W   = 66;
  localparam int unsigned ROOT_W  = 34;
  localparam int unsigned LEN_W   = 35;
  localparam int unsigned QUO_W   = 31;
  localparam int unsigned TERM_W  = 62;

  localparam logic [TERM_W-1:0] TERM_CAP = {TERM_W{1'b1}};

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_LEN  = 3'd5;

  typedef struct packed {
    logic [2:0]              neg;
    logic [2:0][COORD_W-1:0] vel;
  } dir_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    dir_t                  dir;
  } vec_t;

endpackage

### src/lsd_sqrt.sv
// ----------------------------------------------------------------------------
// lsd_sqrt
// Pipelined floor square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module lsd_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [lsd_pkg::SUM_W-1:0]    rad,
  input  lsd_pkg::vec_t                in_side,
  output logic                         out_valid,
  output logic [lsd_pkg::ROOT_W-1:0]   root,
  output lsd_pkg::vec_t                out_side
);

  localparam int N  = lsd_pkg::ROOT_W;
  localparam int TW = 2 * lsd_pkg::ROOT_W + 1;

  logic                         v_r    [N];
  logic [lsd_pkg::SUM_W-1:0]    rem_r  [N];
  logic [lsd_pkg::ROOT_W-1:0]   res_r  [N];
  lsd_pkg::vec_t                side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int B = N - 1 - k;
    logic                       v_p;
    logic [lsd_pkg::SUM_W-1:0]  rem_p;
    logic [lsd_pkg::ROOT_W-1:0] res_p;
    lsd_pkg::vec_t              side_p;
    logic [TW-1:0]              trial;
    logic                       ge;
    logic [lsd_pkg::SUM_W-1:0]  rem_nxt;
    logic [lsd_pkg::ROOT_W-1:0] res_nxt;

    if (k == 0) begin : g_head
      assign v_p    = in_valid;
      assign rem_p  = rad;
      assign res_p  = '0;
      assign side_p = in_side;
    end else begin : g_body
      assign v_p    = v_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign res_p  = res_r[k-1];
      assign side_p = side_r[k-1];
    end

    always_comb begin
      trial   = (TW'(res_p) << (B + 1)) + (TW'(1) << (2 * B));
      ge      = TW'(rem_p) >= trial;
      rem_nxt = ge ? rem_p - trial[lsd_pkg::SUM_W-1:0] : rem_p;
      res_nxt = ge ? res_p | (lsd_pkg::ROOT_W'(1) << B) : res_p;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        res_r[k]  <= res_nxt;
        side_r[k] <= side_p;
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign root      = res_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

### src/lsd_div.sv
// ----------------------------------------------------------------------------
// lsd_div
// Three-lane pipelined restoring divider forming the unit-vector
// magnitudes (mag << 30) / len, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lsd_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [lsd_pkg::ROOT_W-1:0]          in_len,
  input  logic [2:0][lsd_pkg::MAG_W-1:0]      in_mag,
  input  lsd_pkg::dir_t                       in_dir,
  output logic                                out_valid,
  output logic [lsd_pkg::ROOT_W-1:0]          out_len,
  output logic [2:0][lsd_pkg::QUO_W-1:0]      out_quo,
  output lsd_pkg::dir_t                       out_dir
);

  localparam int N  = lsd_pkg::QUO_W;
  localparam int RW = lsd_pkg::ROOT_W + 1;

  logic                              v_r   [N];
  logic [lsd_pkg::ROOT_W-1:0]        len_r [N];
  logic [2:0][RW-1:0]                rem_r [N];
  logic [2:0][lsd_pkg::QUO_W-1:0]    quo_r [N];
  lsd_pkg::dir_t                     dir_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int J = N - 1 - k;
    logic                           v_p;
    logic [lsd_pkg::ROOT_W-1:0]     len_p;
    logic [2:0][RW-1:0]             t_p;
    logic [2:0][lsd_pkg::QUO_W-1:0] quo_p;
    lsd_pkg::dir_t                  dir_p;
    logic [2:0][RW-1:0]             rem_nxt;
    logic [2:0][lsd_pkg::QUO_W-1:0] quo_nxt;

    if (k == 0) begin : g_head
      assign v_p   = in_valid;
      assign len_p = in_len;
      assign quo_p = '0;
      assign dir_p = in_dir;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign t_p[l] = RW'(in_mag[l]);
      end
    end else begin : g_body
      assign v_p   = v_r[k-1];
      assign len_p = len_r[k-1];
      assign quo_p = quo_r[k-1];
      assign dir_p = dir_r[k-1];
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign t_p[l] = rem_r[k-1][l] << 1;
      end
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (t_p[l] >= RW'(len_p)) begin
          rem_nxt[l] = t_p[l] - RW'(len_p);
          quo_nxt[l] = quo_p[l] | (lsd_pkg::QUO_W'(1) << J);
        end else begin
          rem_nxt[l] = t_p[l];
          quo_nxt[l] = quo_p[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        len_r[k] <= len_p;
        rem_r[k] <= rem_nxt;
        quo_r[k] <= quo_nxt;
        dir_r[k] <= dir_p;
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_len   = len_r[N-1];
  assign out_quo   = quo_r[N-1];
  assign out_dir   = dir_r[N-1];

endmodule

### src/lsd_force.sv
// ----------------------------------------------------------------------------
// lsd_force
// Eight-stage back end: projection, spring and damping terms, scalar
// force and saturated per-axis force.
// ----------------------------------------------------------------------------
module lsd_force #(
  parameter int unsigned FRAC_BITS = lsd_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [lsd_pkg::ROOT_W-1:0]         in_len,
  input  logic [2:0][lsd_pkg::QUO_W-1:0]     in_quo,
  input  lsd_pkg::dir_t                      in_dir,
  input  logic [31:0]                        stiffness,
  input  logic [31:0]                        damping,
  input  logic [31:0]                        rest_len,
  output logic                               out_valid,
  output logic [2:0][31:0]                   out_force,
  output logic [lsd_pkg::ROOT_W-1:0]         out_len,
  output logic                               out_sat
);

  localparam int QW  = lsd_pkg::QUO_W;
  localparam int RTW = lsd_pkg::ROOT_W;
  localparam int LW  = lsd_pkg::LEN_W;
  localparam int TW  = lsd_pkg::TERM_W;
  localparam int SPW = 32 + RTW;
  localparam int DPW = 32 + 63;
  localparam int FPW = 63 + 32;

  logic [7:0] v_r;

  // stage 1
  logic signed [2:0][63:0] b1_p_r;
  logic [2:0]              b1_uneg_r;
  logic [2:0][QW-1:0]      b1_umag_r;
  logic                    b1_eneg_r;
  logic [RTW-1:0]          b1_emag_r;
  logic [RTW-1:0]          b1_len_r;
  // stage 2
  logic signed [63:0]      b2_proj_r;
  logic [SPW-1:0]          b2_sprod_r;
  logic [2:0]              b2_uneg_r;
  logic [2:0][QW-1:0]      b2_umag_r;
  logic                    b2_eneg_r;
  logic [RTW-1:0]          b2_len_r;
  // stage 3
  logic [62:0]             b3_pmag_r;
  logic                    b3_pneg_r;
  logic [TW-1:0]           b3_sp_r;
  logic [2:0]              b3_uneg_r;
  logic [2:0][QW-1:0]      b3_umag_r;
  logic                    b3_eneg_r;
  logic [RTW-1:0]          b3_len_r;
  // stage 4
  logic [63:0]             b4_dlo_r;
  logic [62:0]             b4_dhi_r;
  logic                    b4_pneg_r;
  logic [TW-1:0]           b4_sp_r;
  logic [2:0]              b4_uneg_r;
  logic [2:0][QW-1:0]      b4_umag_r;
  logic                    b4_eneg_r;
  logic [RTW-1:0]          b4_len_r;
  // stage 5
  logic [TW-1:0]           b5_dm_r;
  logic                    b5_pneg_r;
  logic [TW-1:0]           b5_sp_r;
  logic [2:0]              b5_uneg_r;
  logic [2:0][QW-1:0]      b5_umag_r;
  logic                    b5_eneg_r;
  logic [RTW-1:0]          b5_len_r;
  // stage 6
  logic                    b6_sneg_r;
  logic [62:0]             b6_smag_r;
  logic [2:0]              b6_uneg_r;
  logic [2:0][QW-1:0]      b6_umag_r;
  logic [RTW-1:0]          b6_len_r;
  // stage 7
  logic [2:0][62:0]        b7_plo_r;
  logic [2:0][61:0]        b7_phi_r;
  logic [2:0]              b7_neg_r;
  logic [RTW-1:0]          b7_len_r;
  // stage 8
  logic [2:0][31:0]        b8_force_r;
  logic                    b8_sat_r;
  logic [RTW-1:0]          b8_len_r;

  logic signed [2:0][63:0] p_nxt;
  logic [2:0]              uneg_nxt;
  logic [2:0][QW-1:0]      umag_nxt;
  logic [LW-1:0]           ext_nxt;
  logic [LW-1:0]           emag_nxt;
  logic [QW-1:0]           unz;
  logic [31:0]             u;

  always_comb begin
    unz = '0;
    u   = '0;
    for (int l = 0; l < 3; l++) begin
      unz         = (in_len == '0) ? '0 : in_quo[l];
      u           = in_dir.neg[l] ? 32'(0) - 32'(unz) : 32'(unz);
      umag_nxt[l] = unz;
      uneg_nxt[l] = in_dir.neg[l] && (unz != '0);
      p_nxt[l]    = $signed(u) * $signed(in_dir.vel[l]);
    end
    ext_nxt  = LW'(in_len) - LW'(rest_len);
    emag_nxt = ext_nxt[LW-1] ? LW'(0) - ext_nxt : ext_nxt;
  end

  logic signed [63:0] proj_nxt;
  logic [SPW-1:0]     sprod_nxt;

  always_comb begin
    proj_nxt  = b1_p_r[0] + b1_p_r[1] + b1_p_r[2];
    sprod_nxt = SPW'(stiffness) * SPW'(b1_emag_r);
  end

  logic [63:0]    pmag_nxt;
  logic [SPW-1:0] spsh;
  logic [TW-1:0]  sp_nxt;

  always_comb begin
    pmag_nxt = b2_proj_r[63] ? 64'(0) - 64'(b2_proj_r) : 64'(b2_proj_r);
    spsh     = b2_sprod_r >> FRAC_BITS;
    sp_nxt   = (spsh > SPW'(lsd_pkg::TERM_CAP)) ? lsd_pkg::TERM_CAP : spsh[TW-1:0];
  end

  logic [DPW-1:0] dprod;
  logic [DPW-1:0] dsh;
  logic [TW-1:0]  dm_nxt;

  always_comb begin
    dprod  = DPW'(b4_dlo_r) + (DPW'(b4_dhi_r) << 32);
    dsh    = dprod >> (lsd_pkg::UNIT_BITS + FRAC_BITS);
    dm_nxt = (dsh > DPW'(lsd_pkg::TERM_CAP)) ? lsd_pkg::TERM_CAP : dsh[TW-1:0];
  end

  logic [63:0] s_sp;
  logic [63:0] s_dm;
  logic [63:0] s_nxt;
  logic [63:0] smag_nxt;

  always_comb begin
    s_sp     = b5_eneg_r ? 64'(b5_sp_r) : 64'(0) - 64'(b5_sp_r);
    s_dm     = b5_pneg_r ? 64'(b5_dm_r) : 64'(0) - 64'(b5_dm_r);
    s_nxt    = s_sp + s_dm;
    smag_nxt = s_nxt[63] ? 64'(0) - s_nxt : s_nxt;
  end

  logic [2:0][62:0] plo_nxt;
  logic [2:0][61:0] phi_nxt;
  logic [2:0]       neg_nxt;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      plo_nxt[l] = 63'(b6_smag_r[31:0]) * 63'(b6_umag_r[l]);
      phi_nxt[l] = 62'(b6_smag_r[62:32]) * 62'(b6_umag_r[l]);
      neg_nxt[l] = b6_sneg_r != b6_uneg_r[l];
    end
  end

  logic [FPW-1:0]   full;
  logic [63:0]      q;
  logic [63:0]      lim;
  logic [63:0]      m;
  logic [2:0][31:0] force_nxt;
  logic             sat_nxt;

  always_comb begin
    full    = '0;
    q       = '0;
    lim     = '0;
    m       = '0;
    sat_nxt = 1'b0;
    for (int l = 0; l < 3; l++) begin
      full = FPW'(b7_plo_r[l]) + (FPW'(b7_phi_r[l]) << 32);
      q    = full[lsd_pkg::UNIT_BITS +: 64];
      lim  = b7_neg_r[l] ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
      if (q > lim) begin
        m       = lim;
        sat_nxt = 1'b1;
      end else begin
        m = q;
      end
      force_nxt[l] = b7_neg_r[l] ? 32'(0) - m[31:0] : m[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_p_r     <= p_nxt;
      b1_uneg_r  <= uneg_nxt;
      b1_umag_r  <= umag_nxt;
      b1_eneg_r  <= ext_nxt[LW-1];
      b1_emag_r  <= emag_nxt[RTW-1:0];
      b1_len_r   <= in_len;

      b2_proj_r  <= proj_nxt;
      b2_sprod_r <= sprod_nxt;
      b2_uneg_r  <= b1_uneg_r;
      b2_umag_r  <= b1_umag_r;
      b2_eneg_r  <= b1_eneg_r;
      b2_len_r   <= b1_len_r;

      b3_pmag_r  <= pmag_nxt[62:0];
      b3_pneg_r  <= b2_proj_r[63];
      b3_sp_r    <= sp_nxt;
      b3_uneg_r  <= b2_uneg_r;
      b3_umag_r  <= b2_umag_r;
      b3_eneg_r  <= b2_eneg_r;
      b3_len_r   <= b2_len_r;

      b4_dlo_r   <= 64'(damping) * 64'(b3_pmag_r[31:0]);
      b4_dhi_r   <= 63'(damping) * 63'(b3_pmag_r[62:32]);
      b4_pneg_r  <= b3_pneg_r;
      b4_sp_r    <= b3_sp_r;
      b4_uneg_r  <= b3_uneg_r;
      b4_umag_r  <= b3_umag_r;
      b4_eneg_r  <= b3_eneg_r;
      b4_len_r   <= b3_len_r;

      b5_dm_r    <= dm_nxt;
      b5_pneg_r  <= b4_pneg_r;
      b5_sp_r    <= b4_sp_r;
      b5_uneg_r  <= b4_uneg_r;
      b5_umag_r  <= b4_umag_r;
      b5_eneg_r  <= b4_eneg_r;
      b5_len_r   <= b4_len_r;

      b6_sneg_r  <= s_nxt[63];
      b6_smag_r  <= smag_nxt[62:0];
      b6_uneg_r  <= b5_uneg_r;
      b6_umag_r  <= b5_umag_r;
      b6_len_r   <= b5_len_r;

      b7_plo_r   <= plo_nxt;
      b7_phi_r   <= phi_nxt;
      b7_neg_r   <= neg_nxt;
      b7_len_r   <= b6_len_r;

      b8_force_r <= force_nxt;
      b8_sat_r   <= sat_nxt;
      b8_len_r   <= b7_len_r;
    end
  end

  assign out_valid = v_r[7];
  assign out_force = b8_force_r;
  assign out_len   = b8_len_r;
  assign out_sat   = b8_sat_r;

endmodule

### src/linear_spring_damper_force_core.sv
// ----------------------------------------------------------------------------
// linear_spring_damper_force_core
// Spring-damper restraint force from attachment position and velocity.
//
// Input beats carry attachment position and velocity (signed fixed point);
// output beats carry the saturated force vector, the spring length and a
// clip flag. Anchor, stiffness, damping and rest length are written over
// the cfg channel, which is always ready; write them while no beat is in
// flight. Unknown indexes are dropped.
// Throughput: one beat per cycle while the receiver keeps taking output. The
// path from input accept to output valid has 3 front stages (offset, square,
// sum), 34 square-root stages (one root bit each), 31 divider stages (one
// unit-vector bit each) and 8 force stages.
// The whole pipeline advances while the output register is empty or taken;
// when the receiver stalls, every stage holds and in_ready drops, so no
// beat is lost or repeated.
// Reset clears all valid bits and all configuration registers to zero.
// ----------------------------------------------------------------------------
module linear_spring_damper_force_core #(
  parameter int unsigned FRAC_BITS = lsd_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [31:0]                in_attach_x,
  input  logic signed [31:0]                in_attach_y,
  input  logic signed [31:0]                in_attach_z,
  input  logic signed [31:0]                in_vel_x,
  input  logic signed [31:0]                in_vel_y,
  input  logic signed [31:0]                in_vel_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                out_force_x,
  output logic signed [31:0]                out_force_y,
  output logic signed [31:0]                out_force_z,
  output logic [lsd_pkg::LEN_W-1:0]         out_spring_length,
  output logic                              out_force_saturated,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);

  localparam int DW = lsd_pkg::DIFF_W;
  localparam int MW = lsd_pkg::MAG_W;

  logic [31:0] anchor_x_r;
  logic [31:0] anchor_y_r;
  logic [31:0] anchor_z_r;
  logic [31:0] stiffness_r;
  logic [31:0] damping_r;
  logic [31:0] rest_len_r;

  logic en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_x_r  <= '0;
      anchor_y_r  <= '0;
      anchor_z_r  <= '0;
      stiffness_r <= '0;
      damping_r   <= '0;
      rest_len_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        lsd_pkg::CFG_ANCHOR_X:  anchor_x_r  <= cfg_data;
        lsd_pkg::CFG_ANCHOR_Y:  anchor_y_r  <= cfg_data;
        lsd_pkg::CFG_ANCHOR_Z:  anchor_z_r  <= cfg_data;
        lsd_pkg::CFG_STIFFNESS: stiffness_r <= cfg_data;
        lsd_pkg::CFG_DAMPING:   damping_r   <= cfg_data;
        lsd_pkg::CFG_REST_LEN:  rest_len_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // front stage 1: offset from anchor
  logic                  f1_v_r;
  logic [2:0][DW-1:0]    f1_d_r;
  logic [2:0][31:0]      f1_vel_r;
  // front stage 2: magnitude and square
  logic                  f2_v_r;
  logic [2:0][MW-1:0]    f2_mag_r;
  logic [2:0][lsd_pkg::SQ_W-1:0] f2_sq_r;
  lsd_pkg::dir_t         f2_dir_r;
  // front stage 3: sum of squares
  logic                  f3_v_r;
  logic [lsd_pkg::SUM_W-1:0] f3_sum_r;
  lsd_pkg::vec_t         f3_side_r;

  logic [2:0][DW-1:0]    d_nxt;
  logic [2:0][MW-1:0]    mag_nxt;
  logic [2:0]            neg_nxt;

  always_comb begin
    d_nxt[0] = DW'(in_attach_x) - DW'($signed(anchor_x_r));
    d_nxt[1] = DW'(in_attach_y) - DW'($signed(anchor_y_r));
    d_nxt[2] = DW'(in_attach_z) - DW'($signed(anchor_z_r));
    for (int l = 0; l < 3; l++) begin
      neg_nxt[l] = f1_d_r[l][DW-1];
      mag_nxt[l] = neg_nxt[l] ? MW'(0) - f1_d_r[l] : f1_d_r[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= in_valid;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_d_r   <= d_nxt;
      f1_vel_r <= {in_vel_z, in_vel_y, in_vel_x};

      f2_mag_r     <= mag_nxt;
      f2_dir_r.neg <= neg_nxt;
      f2_dir_r.vel <= f1_vel_r;
      for (int l = 0; l < 3; l++) begin
        f2_sq_r[l] <= lsd_pkg::SQ_W'(mag_nxt[l]) * lsd_pkg::SQ_W'(mag_nxt[l]);
      end

      f3_sum_r <= lsd_pkg::SUM_W'(f2_sq_r[0]) + lsd_pkg::SUM_W'(f2_sq_r[1])
                + lsd_pkg::SUM_W'(f2_sq_r[2]);
      f3_side_r.mag <= f2_mag_r;
      f3_side_r.dir <= f2_dir_r;
    end
  end

  logic                              sq_v;
  logic [lsd_pkg::ROOT_W-1:0]        sq_root;
  lsd_pkg::vec_t                     sq_side;

  lsd_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f3_v_r),
    .rad       (f3_sum_r),
    .in_side   (f3_side_r),
    .out_valid (sq_v),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  logic                              dv_v;
  logic [lsd_pkg::ROOT_W-1:0]        dv_len;
  logic [2:0][lsd_pkg::QUO_W-1:0]    dv_quo;
  lsd_pkg::dir_t                     dv_dir;

  lsd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_v),
    .in_len    (sq_root),
    .in_mag    (sq_side.mag),
    .in_dir    (sq_side.dir),
    .out_valid (dv_v),
    .out_len   (dv_len),
    .out_quo   (dv_quo),
    .out_dir   (dv_dir)
  );

  logic [2:0][31:0]                  force_w;
  logic [lsd_pkg::ROOT_W-1:0]        len_w;

  lsd_force #(
    .FRAC_BITS (FRAC_BITS)
  ) u_force (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv_v),
    .in_len    (dv_len),
    .in_quo    (dv_quo),
    .in_dir    (dv_dir),
    .stiffness (stiffness_r),
    .damping   (damping_r),
    .rest_len  (rest_len_r),
    .out_valid (out_valid),
    .out_force (force_w),
    .out_len   (len_w),
    .out_sat   (out_force_saturated)
  );

  assign out_force_x       = force_w[0];
  assign out_force_y       = force_w[1];
  assign out_force_z       = force_w[2];
  assign out_spring_length = lsd_pkg::LEN_W'(len_w);

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams attachment position and velocity beats through the spring-damper
// force core under several anchor, stiffness, damping and rest-length
// settings, and compares every force, length and clip flag against an
// independent fixed-point prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned FB = 16;
  localparam int LATENCY = 76;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic [lsd_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [lsd_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    logic signed [31:0]        fx;
    logic signed [31:0]        fy;
    logic signed [31:0]        fz;
    logic [lsd_pkg::LEN_W-1:0] len;
    logic                      sat;
  } force_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_attach_x = '0, in_attach_y = '0, in_attach_z = '0;
  logic signed [31:0] in_vel_x = '0, in_vel_y = '0, in_vel_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_force_x, out_force_y, out_force_z;
  logic [lsd_pkg::LEN_W-1:0] out_spring_length;
  logic out_force_saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lsd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic signed [31:0] anchor [3];
  logic [31:0] stiff, damp, rest;
  force_t force_queue [$];
  int mismatches = 0;
  int results_seen = 0;
  int saturations = 0;
  int ready_hold = 0;
  bit stall_enable = 1'b1;
  longint cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  linear_spring_damper_force_core dut (.*);

  // truncate magnitude, keep sign
  function automatic logic signed [191:0] shr_t(input logic signed [191:0] v, input int sh);
    logic [191:0] m;
    begin
      m = (v < 0) ? -v : v;
      m = m >> sh;
      return (v < 0) ? -$signed(m) : $signed(m);
    end
  endfunction

  function automatic force_t predict_force(input logic signed [31:0] p [3],
                                           input logic signed [31:0] v [3]);
    logic signed [191:0] d [3], u [3], proj, ext, sp, dm, s, f;
    logic [191:0] sumsq, root, cand, q;
    force_t r;
    begin
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = $signed(p[i]) - $signed(anchor[i]);
        sumsq += d[i] * d[i];
      end
      root = 0;
      for (int b = 33; b >= 0; b--) begin
        cand = root | (192'd1 << b);
        if (cand * cand <= sumsq) root = cand;
      end
      proj = 0;
      for (int i = 0; i < 3; i++) begin
        if (root == 0) u[i] = 0;
        else begin
          q = ((d[i] < 0 ? -d[i] : d[i]) << lsd_pkg::UNIT_BITS) / root;
          u[i] = d[i] < 0 ? -$signed(q) : $signed(q);
        end
        proj += u[i] * $signed(v[i]);
      end
      ext = $signed(root) - $signed({160'd0, rest});
      sp = shr_t($signed({160'd0, stiff}) * ext, FB);
      if (sp > $signed({130'd0, lsd_pkg::TERM_CAP})) sp = {130'd0, lsd_pkg::TERM_CAP};
      if (sp < -$signed({130'd0, lsd_pkg::TERM_CAP}))
        sp = -$signed({130'd0, lsd_pkg::TERM_CAP});
      dm = shr_t($signed({160'd0, damp}) * proj, lsd_pkg::UNIT_BITS + FB);
      if (dm > $signed({130'd0, lsd_pkg::TERM_CAP})) dm = {130'd0, lsd_pkg::TERM_CAP};
      if (dm < -$signed({130'd0, lsd_pkg::TERM_CAP}))
        dm = -$signed({130'd0, lsd_pkg::TERM_CAP});
      s = -sp - dm;
      r.sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
        f = shr_t(s * u[i], lsd_pkg::UNIT_BITS);
        if (f > 192'sh7FFFFFFF) begin f = 192'sh7FFFFFFF; r.sat = 1'b1; end
        if (f < -192'sh80000000) begin f = -192'sh80000000; r.sat = 1'b1; end
        if (i == 0) r.fx = f[31:0];
        else if (i == 1) r.fy = f[31:0];
        else r.fz = f[31:0];
      end
      r.len = root[lsd_pkg::LEN_W-1:0];
      return r;
    end
  endfunction

  task automatic write_reg(input logic [lsd_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      lsd_pkg::CFG_ANCHOR_X:  anchor[0] = val;
      lsd_pkg::CFG_ANCHOR_Y:  anchor[1] = val;
      lsd_pkg::CFG_ANCHOR_Z:  anchor[2] = val;
      lsd_pkg::CFG_STIFFNESS: stiff = val;
      lsd_pkg::CFG_DAMPING:   damp = val;
      lsd_pkg::CFG_REST_LEN:  rest = val;
      default: ;
    endcase
  endtask

  task automatic send_beat(input logic signed [31:0] p [3], input logic signed [31:0] v [3]);
    if (stall_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_attach_x <= p[0]; in_attach_y <= p[1]; in_attach_z <= p[2];
    in_vel_x <= v[0]; in_vel_y <= v[1]; in_vel_z <= v[2];
    force_queue.push_back(predict_force(p, v));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (force_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_spring(input logic [31:0] ax, ay, az, k, c, rl);
    write_reg(lsd_pkg::CFG_ANCHOR_X, ax);
    write_reg(lsd_pkg::CFG_ANCHOR_Y, ay);
    write_reg(lsd_pkg::CFG_ANCHOR_Z, az);
    write_reg(lsd_pkg::CFG_STIFFNESS, k);
    write_reg(lsd_pkg::CFG_DAMPING, c);
    write_reg(lsd_pkg::CFG_REST_LEN, rl);
  endtask

  function automatic logic [31:0] rand_word(input int mode);
    case (mode)
      0: return $urandom_range(0, 8) << 16;
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      2: return $signed($urandom_range(0, 400000)) - 200000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input int count);
    logic signed [31:0] p [3], v [3];
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 3; i++) begin
        p[i] = rand_word($urandom_range(0, 3));
        v[i] = rand_word($urandom_range(0, 3));
      end
      if ($urandom_range(0, 15) == 0) p = anchor;
      send_beat(p, v);
    end
  endtask

  task automatic test_reset_defaults();
    logic signed [31:0] p [3], v [3];
    p = '{0, 0, 0}; v = '{32'h7FFFFFFF, 0, 0};
    send_beat(p, v);
    p = '{32'sh00010000, 0, 0};
    send_beat(p, v);
    drain();
  endtask

  task automatic test_directed();
    logic signed [31:0] p [3], v [3];
    set_spring(32'h00010000, 32'hFFFE0000, 0, 32'h00020000, 32'h00008000, 32'h00018000);
    p = anchor; v = '{32'h00010000, 0, 0};
    send_beat(p, v);
    p = '{32'h00040000, 32'hFFFE0000, 0}; v = '{32'hFFFF0000, 0, 32'h00050000};
    send_beat(p, v);
    p = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
    v = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
    send_beat(p, v);
    p = '{32'h80000000, 32'h80000000, 32'h80000000};
    v = '{32'h80000000, 32'h80000000, 32'h80000000};
    send_beat(p, v);
    p = '{32'h80000000, 32'h7FFFFFFF, 0}; v = '{0, 32'h80000000, 32'h7FFFFFFF};
    send_beat(p, v);
    p = '{32'h00010001, 32'hFFFE0000, 0}; v = '{0, 0, 0};
    send_beat(p, v);
    drain();
  endtask

  task automatic test_extreme_settings();
    set_spring(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF,
               32'hFFFFFFFF);
    send_random(12);
    drain();
    set_spring(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 0, 0);
    write_reg(CFG_SPARE_A, 32'hDEADBEEF);
    write_reg(CFG_SPARE_B, 32'h12345678);
    send_random(12);
    drain();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 6; ph++) begin
      set_spring($urandom, $urandom, $urandom, $urandom_range(0, 3) == 0 ? $urandom :
                 $urandom_range(0, 32'h00100000), $urandom_range(0, 1) ? $urandom :
                 $urandom_range(0, 32'h00040000), $urandom);
      send_random(60);
      drain();
    end
    stall_enable = 1'b0;
    send_random(40);
    drain();
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (stall_enable && ready_hold != 0) begin
        ready_hold--;
        out_ready <= 1'b0;
      end else if (stall_enable && $urandom_range(0, 9) == 0) begin
        ready_hold = $urandom_range(0, 13);
        out_ready <= 1'b0;
      end else begin
        ready_hold = 0;
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    force_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_force_x, out_force_y, out_force_z, out_spring_length, out_force_saturated};
      results_seen++;
      if (got.sat) saturations++;
      if (force_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat: %p", got);
      end else begin
        want = force_queue.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected fx=%0d fy=%0d fz=%0d len=%0d sat=%0b",
                     want.fx, want.fy, want.fz, want.len, want.sat);
            $display("          got      fx=%0d fy=%0d fz=%0d len=%0d sat=%0b",
                     got.fx, got.fy, got.fz, got.len, got.sat);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    anchor = '{0, 0, 0};
    stiff = 0; damp = 0; rest = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_extreme_settings();
    test_random_phases();
    $display("covered %0d force beats (%0d clipped) over 10 spring settings",
             results_seen, saturations);
    if (mismatches == 0 && force_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d beats missing", mismatches, force_queue.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
